// ----- rtl/core/bgi_pkg.sv -----
// Package: shared constants, command codes and structs for the bicubic grid interpolator
`timescale 1ns / 1ps
package bgi_pkg;
    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_MAX_COLS  = 64;
    localparam int DEF_FRAC_BITS = 10;

    localparam int CFG_W     = 7;
    localparam int SAMPLE_W  = 16;
    localparam int COORD_W   = 18;
    localparam int RESULT_W  = 20;
    localparam int ACC_W     = 48;

    localparam logic [0:0] CMD_WRITE = 1'b0;
    localparam logic [0:0] CMD_QUERY = 1'b1;

    localparam logic [CFG_W-1:0] REG_GRID_ROWS = 7'd0;
    localparam logic [CFG_W-1:0] REG_GRID_COLS = 7'd1;

    // controller -> datapath commands
    typedef struct packed {
        logic       load;      // capture query, clamp
        logic       rd;        // issue grid read
        logic [1:0] rd_i;      // tap within row
        logic [1:0] rd_j;      // row of neighborhood
        logic       cap;       // capture read data into tap i
        logic [1:0] cap_i;
        logic       cub_go;    // start a cubic on taps or row results
        logic       cub_y;     // 1: cubic along y on row results
        logic       row_wr;    // store cubic result as row j
        logic [1:0] row_j;
        logic       fin;       // produce result
    } t_cmd;

    typedef struct packed {
        logic cub_done;
    } t_sts;
endpackage

// ----- rtl/core/bgi_ctrl.sv -----
// Controller: sequences reads, cubics and result for one query
`timescale 1ns / 1ps
module bgi_ctrl
    import bgi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_query,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLMP = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CUBX = 3'd3;
    localparam logic [2:0] S_CUBY = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_i, n_i, r_j, n_j;
    logic       r_capv, n_capv;
    logic [1:0] r_capi, n_capi;
    logic       r_started, n_started;

    always_comb begin
        n_state = r_state; n_i = r_i; n_j = r_j;
        n_capv = 1'b0; n_capi = r_i; n_started = r_started;
        o_cmd = '0;
        o_cmd.cap = r_capv; o_cmd.cap_i = r_capi;
        o_cmd.rd_i = r_i; o_cmd.rd_j = r_j; o_cmd.row_j = r_j;
        unique case (r_state)
            S_IDLE: begin
                if (i_query) begin
                    o_cmd.load = 1'b1; n_state = S_CLMP;
                end
            end
            S_CLMP: begin
                n_i = 2'd0; n_j = 2'd0; n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1; n_capv = 1'b1; n_capi = r_i;
                n_i = r_i + 2'd1;
                if (r_i == 2'd3) begin
                    n_state = S_CUBX; n_started = 1'b0;
                end
            end
            S_CUBX: begin
                if (!r_started && !r_capv) begin
                    o_cmd.cub_go = 1'b1; n_started = 1'b1;
                end else if (r_started && i_sts.cub_done) begin
                    o_cmd.row_wr = 1'b1; n_j = r_j + 2'd1; n_started = 1'b0;
                    n_state = (r_j == 2'd3) ? S_CUBY : S_READ;
                end
            end
            S_CUBY: begin
                if (!r_started) begin
                    o_cmd.cub_go = 1'b1; o_cmd.cub_y = 1'b1; n_started = 1'b1;
                end else if (i_sts.cub_done) begin
                    n_started = 1'b0; n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_i <= '0; r_j <= '0;
            r_capv <= 1'b0; r_capi <= '0; r_started <= 1'b0;
        end else begin
            r_state <= n_state; r_i <= n_i; r_j <= n_j;
            r_capv <= n_capv; r_capi <= n_capi; r_started <= n_started;
        end
    end
endmodule

// ----- rtl/core/bgi_dp.sv -----
// Datapath: grid memory, clamp, index hold, shared-multiplier cubic, rounding
`timescale 1ns / 1ps
module bgi_dp
    import bgi_pkg::*;
#(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [5:0]                 i_write_row,
    input  logic [5:0]                 i_write_col,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic signed [COORD_W-1:0]  i_query_x,
    input  logic signed [COORD_W-1:0]  i_query_y,
    input  logic [CFG_W-1:0]           i_rows,
    input  logic [CFG_W-1:0]           i_cols,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    output logic                       o_valid,
    output logic signed [RESULT_W-1:0] o_value,
    output logic                       o_clamped
);
    localparam int RB    = $clog2(MAX_ROWS);
    localparam int CB    = $clog2(MAX_COLS);
    localparam int AB    = RB + CB;
    localparam int DEPTH = 1 << AB;
    localparam int SB    = 10;            // effective size width, holds up to 1023
    localparam logic signed [ACC_W-1:0] OFF =
        ACC_W'(((101 << FRAC_BITS) + 99) / 100);
    localparam logic signed [ACC_W-1:0] ONE = ACC_W'(1) <<< FRAC_BITS;

    // grid memory
    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rdata;
    logic [AB-1:0]              rd_addr;

    // effective sizes
    logic [SB-1:0] rows_e, cols_e;
    always_comb begin
        rows_e = (i_rows == '0) ? SB'(1) :
                 (SB'(i_rows) > SB'(MAX_ROWS)) ? SB'(MAX_ROWS) : SB'(i_rows);
        cols_e = (i_cols == '0) ? SB'(1) :
                 (SB'(i_cols) > SB'(MAX_COLS)) ? SB'(MAX_COLS) : SB'(i_cols);
    end

    // query capture and clamp
    logic signed [ACC_W-1:0] r_x, r_y;
    logic                    r_clamped;
    logic [SB-1:0]           r_rows, r_cols;
    logic signed [ACC_W-1:0] xs, ys, xhi, yhi, xl, yl, xc, yc;
    logic                    in_grid;
    always_comb begin
        xs  = ACC_W'(i_query_x);
        ys  = ACC_W'(i_query_y);
        xl  = ACC_W'(cols_e - SB'(1)) <<< FRAC_BITS;
        yl  = ACC_W'(rows_e - SB'(1)) <<< FRAC_BITS;
        xhi = (ACC_W'(cols_e) <<< FRAC_BITS) - OFF;
        yhi = (ACC_W'(rows_e) <<< FRAC_BITS) - OFF;
        in_grid = (xs >= 0) && (xs < xl) && (ys >= 0) && (ys < yl);
        xc = (xs > xhi) ? xhi : xs;
        xc = (xc < 0) ? '0 : xc;
        yc = (ys > yhi) ? yhi : ys;
        yc = (yc < 0) ? '0 : yc;
    end

    // cell and fraction
    logic [SB-1:0]          x0, y0;
    logic [FRAC_BITS-1:0]   dx, dy;
    assign x0 = SB'(r_x >>> FRAC_BITS);
    assign y0 = SB'(r_y >>> FRAC_BITS);
    assign dx = r_x[FRAC_BITS-1:0];
    assign dy = r_y[FRAC_BITS-1:0];

    // neighbor index hold
    logic signed [SB+1:0] xi_raw, yi_raw;
    logic [CB-1:0] xi;
    logic [RB-1:0] yi;
    always_comb begin
        xi_raw = $signed({2'b00, x0}) + $signed((SB+2)'(i_cmd.rd_i)) - (SB+2)'(1);
        yi_raw = $signed({2'b00, y0}) + $signed((SB+2)'(i_cmd.rd_j)) - (SB+2)'(1);
        if (xi_raw < 0) xi = '0;
        else if (xi_raw >= $signed({2'b00, r_cols})) xi = CB'(r_cols - SB'(1));
        else xi = CB'(xi_raw);
        if (yi_raw < 0) yi = '0;
        else if (yi_raw >= $signed({2'b00, r_rows})) yi = RB'(r_rows - SB'(1));
        else yi = RB'(yi_raw);
        rd_addr = {yi, xi};
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && (32'(i_write_row) < MAX_ROWS) && (32'(i_write_col) < MAX_COLS))
            mem[{RB'(i_write_row), CB'(i_write_col)}] <= i_sample_value;
        if (i_cmd.rd)
            r_rdata <= mem[rd_addr];
    end

    // taps and row results
    logic signed [ACC_W-1:0] r_tap [4];
    logic signed [ACC_W-1:0] r_row [4];

    // cubic: shared multiplier, three Horner steps
    logic [1:0]              r_step;
    logic                    r_run, r_done;
    logic signed [ACC_W-1:0] r_acc, r_a, r_b, r_p1, r_prod;
    logic                    r_phase;  // 0: multiply, 1: accumulate
    logic                    r_isy;
    logic signed [ACC_W-1:0] q0, q1, q2, q3, cc, bb, aa;
    logic [FRAC_BITS-1:0]    dsel;
    logic signed [ACC_W-1:0] rnd_v, sum_v;
    logic [4:0]              sh;

    always_comb begin
        q0 = i_cmd.cub_y ? r_row[0] : r_tap[0];
        q1 = i_cmd.cub_y ? r_row[1] : r_tap[1];
        q2 = i_cmd.cub_y ? r_row[2] : r_tap[2];
        q3 = i_cmd.cub_y ? r_row[3] : r_tap[3];
        aa = q2 - q0;
        bb = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
        cc = ((q1 - q2) <<< 1) + (q1 - q2) + q3 - q0;
        dsel = r_isy ? dy : dx;
        sh = (r_step == 2'd2) ? 5'(FRAC_BITS + 1) : 5'(FRAC_BITS);
        rnd_v = (r_prod + (ACC_W'(1) <<< (sh - 5'd1))) >>> sh;
        sum_v = (r_step == 2'd0) ? (r_b + rnd_v) :
                (r_step == 2'd1) ? (r_a + rnd_v) : (r_p1 + rnd_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0; r_done <= 1'b0; r_phase <= 1'b0; r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.cub_go) begin
                r_run <= 1'b1; r_phase <= 1'b0; r_step <= '0;
            end else if (r_run) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd2) begin
                        r_run <= 1'b0; r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // acc walks c -> h -> g -> result; product of d and acc in between
    always_ff @(posedge i_clk) begin
        if (i_cmd.cub_go) begin
            r_acc <= cc; r_a <= aa; r_b <= bb; r_p1 <= q1; r_isy <= i_cmd.cub_y;
        end else if (r_run) begin
            if (!r_phase) r_prod <= $signed({1'b0, dsel}) * r_acc;
            else          r_acc  <= sum_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= in_grid ? xs : xc;
            r_y <= in_grid ? ys : yc;
            r_clamped <= ~in_grid;
            r_rows <= rows_e; r_cols <= cols_e;
        end
        if (i_cmd.cap) r_tap[i_cmd.cap_i] <= ACC_W'(r_rdata) <<< FRAC_BITS;
        if (i_cmd.row_wr) r_row[i_cmd.row_j] <= r_acc;
    end

    assign o_sts.cub_done = r_done;

    // final rounding and saturation
    logic signed [ACC_W-1:0] fv;
    localparam logic signed [ACC_W-1:0] VMAX = ACC_W'((1 << (RESULT_W-1)) - 1);
    localparam logic signed [ACC_W-1:0] VMIN = -ACC_W'(1 << (RESULT_W-1));
    assign fv = (r_acc + (ONE >>> 1)) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= i_cmd.fin;
        if (i_cmd.fin) begin
            o_value   <= (fv > VMAX) ? RESULT_W'(VMAX) :
                         (fv < VMIN) ? RESULT_W'(VMIN) : RESULT_W'(fv);
            o_clamped <= r_clamped;
        end
    end
endmodule

// ----- rtl/core/bicubic_grid_interpolator.sv -----
// Top level: bicubic grid interpolator, controller plus datapath
//
//  channel | direction | handshake             | payload
//  cfg     | in        | i_cfg_we              | i_cfg_index, i_cfg_data
//  cmd     | in        | start & !busy         | command, write, sample, query x/y
//  result  | out       | o_done (one cycle)    | interpolated_value, was_clamped
//
// A write beat leaves busy low. A query beat holds busy while it sets up, then
// for each neighborhood row makes four reads from the grid memory, captures the
// last tap, runs the cubic's multiply/add steps on the shared multiplier and
// stores the row result; then the cubic along y, then rounding. o_done comes
// in the same cycle as busy falls; new queries wait for busy low. Reset
// (synchronous, active low) clears control and the size registers to 4; the
// grid is undefined until written. The receiver cannot stall the result.
`timescale 1ns / 1ps
module bicubic_grid_interpolator
    import bgi_pkg::*;
#(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_command,
    input  logic [5:0]                 i_write_row,
    input  logic [5:0]                 i_write_col,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic signed [COORD_W-1:0]  i_query_x,
    input  logic signed [COORD_W-1:0]  i_query_y,
    output logic                       o_done,
    output logic signed [RESULT_W-1:0] o_interpolated_value,
    output logic                       o_was_clamped
);
    logic [CFG_W-1:0] r_rows, r_cols;
    t_cmd cmd;
    t_sts sts;
    logic accept;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 7'd4; r_cols <= 7'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GRID_ROWS: r_rows <= i_cfg_data;
                REG_GRID_COLS: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bgi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_query (accept && (i_command == CMD_QUERY)),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bgi_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (accept && (i_command == CMD_WRITE)),
        .i_write_row   (i_write_row),
        .i_write_col   (i_write_col),
        .i_sample_value(i_sample_value),
        .i_query_x     (i_query_x),
        .i_query_y     (i_query_y),
        .i_rows        (r_rows),
        .i_cols        (r_cols),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_done),
        .o_value       (o_interpolated_value),
        .o_clamped     (o_was_clamped)
    );
endmodule

// ----- rtl/core/bgi_checker.sv -----
// Checker: port-level properties of the interpolator, bound to the top level
`timescale 1ns / 1ps
module bgi_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_command,
    input logic o_done
);
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_command) |=> !busy) else $error("write raised busy");
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command) |=> busy) else $error("query not taken");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result beat repeated");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(busy)) else $error("result without query");
endmodule

bind bicubic_grid_interpolator bgi_checker u_bgi_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_command(i_command),
    .o_done   (o_done)
);

// ----- tb/bicubic_grid_interpolator_checker.sv -----
// Checker: watches the bicubic grid interpolator ports, predicts results and compares
`timescale 1ns / 1ps
module bicubic_grid_interpolator_checker
    import bgi_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic                       i_command,
    input  logic [5:0]                 i_write_row,
    input  logic [5:0]                 i_write_col,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic signed [COORD_W-1:0]  i_query_x,
    input  logic signed [COORD_W-1:0]  i_query_y,
    input  logic                       i_done,
    input  logic signed [RESULT_W-1:0] i_interpolated_value,
    input  logic                       i_was_clamped,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_results
);
    localparam int  FB  = DEF_FRAC_BITS;
    localparam longint ONE = longint'(1) << FB;

    typedef struct packed {
        logic signed [RESULT_W-1:0] value;
        logic                       clamped;
    } t_interp;

    logic signed [SAMPLE_W-1:0] grid_mem [0:DEF_MAX_ROWS*DEF_MAX_COLS-1];
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    t_interp          interp_q [$];
    int               fails = 0;
    int               results = 0;

    assign o_fail_count = fails;
    assign o_pending    = interp_q.size();
    assign o_results    = results;

    // divide by 2^k, nearest, ties up
    function automatic longint round_shift(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint eff_size(logic [CFG_W-1:0] r, longint maxv);
        if (r == 0) return 1;
        if (longint'(r) > maxv) return maxv;
        return longint'(r);
    endfunction

    function automatic longint catmull(longint p0, longint p1, longint p2, longint p3,
                                       longint d);
        longint a, b, c, h, g;
        a = p2 - p0;
        b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c = 3 * (p1 - p2) + p3 - p0;
        h = b + round_shift(d * c, FB);
        g = a + round_shift(d * h, FB);
        return p1 + round_shift(d * g, FB + 1);
    endfunction

    function automatic longint clamp_coord(longint v, longint size);
        longint hi;
        hi = size * ONE - ((longint'(101) * ONE + 99) / 100);
        if (v > hi) v = hi;
        if (v < 0) v = 0;
        return v;
    endfunction

    function automatic t_interp predict_point(longint x, longint y);
        t_interp r;
        longint rows, cols, x0, y0, dx, dy, v, yi, xi;
        longint p [4];
        longint rowv [4];
        logic in_grid;
        rows = eff_size(rows_reg, DEF_MAX_ROWS);
        cols = eff_size(cols_reg, DEF_MAX_COLS);
        in_grid = x >= 0 && x < (cols - 1) * ONE && y >= 0 && y < (rows - 1) * ONE;
        if (!in_grid) begin
            x = clamp_coord(x, cols);
            y = clamp_coord(y, rows);
        end
        x0 = x / ONE;
        y0 = y / ONE;
        dx = x - x0 * ONE;
        dy = y - y0 * ONE;
        for (int j = 0; j < 4; j++) begin
            yi = y0 + j - 1;
            if (yi < 0) yi = 0;
            if (yi >= rows) yi = rows - 1;
            for (int i = 0; i < 4; i++) begin
                xi = x0 + i - 1;
                if (xi < 0) xi = 0;
                if (xi >= cols) xi = cols - 1;
                p[i] = longint'(grid_mem[yi * DEF_MAX_COLS + xi]) * ONE;
            end
            rowv[j] = catmull(p[0], p[1], p[2], p[3], dx);
        end
        v = round_shift(catmull(rowv[0], rowv[1], rowv[2], rowv[3], dy), FB);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        r.value   = v[RESULT_W-1:0];
        r.clamped = !in_grid;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_interp want;
        if (!i_rst_n) begin
            rows_reg <= 7'd4;
            cols_reg <= 7'd4;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_GRID_ROWS) rows_reg <= i_cfg_data;
                else if (i_cfg_index == REG_GRID_COLS) cols_reg <= i_cfg_data;
            end
            if (i_start && !i_busy) begin
                if (i_command == CMD_WRITE)
                    grid_mem[i_write_row * DEF_MAX_COLS + i_write_col] = i_sample_value;
                else
                    interp_q.push_back(predict_point(longint'(i_query_x),
                                                     longint'(i_query_y)));
            end
            if (i_done) begin
                results++;
                if (interp_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result value=%0d clamped=%0b", $time,
                             i_interpolated_value, i_was_clamped);
                end else begin
                    want = interp_q.pop_front();
                    if (want.value !== i_interpolated_value) begin
                        fails++;
                        $display("%0t: value mismatch expected=%0d actual=%0d", $time,
                                 want.value, i_interpolated_value);
                    end
                    if (want.clamped !== i_was_clamped) begin
                        fails++;
                        $display("%0t: clamp flag mismatch expected=%0b actual=%0b",
                                 $time, want.clamped, i_was_clamped);
                    end
                end
            end
        end
    end
endmodule

// ----- tb/bicubic_grid_interpolator_test.sv -----
// Testbench top: stimulus, configuration phases and verdict for the bicubic grid interpolator
`timescale 1ns / 1ps
module bicubic_grid_interpolator_test;
    import bgi_pkg::*;

    localparam int  ONE       = 1 << DEF_FRAC_BITS;
    localparam int  SETTLE    = 80;
    localparam int  CYCLE_CAP = 1500000;
    localparam int  PHASES    = 8;
    localparam int  PHASE_BEATS = 134;
    localparam int  LOAD_COLS = 8;       // columns loaded in every row

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_W-1:0]           i_cfg_index = '0;
    logic [CFG_W-1:0]           i_cfg_data = '0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       i_command = CMD_WRITE;
    logic [5:0]                 i_write_row = '0;
    logic [5:0]                 i_write_col = '0;
    logic signed [SAMPLE_W-1:0] i_sample_value = '0;
    logic signed [COORD_W-1:0]  i_query_x = '0;
    logic signed [COORD_W-1:0]  i_query_y = '0;
    logic                       o_done;
    logic signed [RESULT_W-1:0] o_interpolated_value;
    logic                       o_was_clamped;

    int fail_count, pending, results;
    int cycles = 0;
    int query_beats = 0, write_beats = 0;
    int burst_left = 0;
    int cur_rows = 4, cur_cols = 4;   // effective sizes, tracked for stimulus shaping

    always #2 i_clk = ~i_clk;

    bicubic_grid_interpolator dut (.*);

    bicubic_grid_interpolator_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_start(start), .i_busy(busy), .i_command, .i_write_row, .i_write_col,
        .i_sample_value, .i_query_x, .i_query_y,
        .i_done(o_done), .i_interpolated_value(o_interpolated_value),
        .i_was_clamped(o_was_clamped),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Present one beat and hold it until the handshake takes it. Start stays
    // high afterward so back-to-back beats never drop it within a step.
    task automatic send_beat(logic cmd, logic [5:0] row, logic [5:0] col,
                             logic signed [SAMPLE_W-1:0] smp,
                             logic signed [COORD_W-1:0] qx, logic signed [COORD_W-1:0] qy);
        start          <= 1'b1;
        i_command      <= cmd;
        i_write_row    <= row;
        i_write_col    <= col;
        i_sample_value <= smp;
        i_query_x      <= qx;
        i_query_y      <= qy;
        do @(posedge i_clk); while (busy);
        if (cmd == CMD_QUERY) query_beats++;
        else write_beats++;
    endtask

    // bursty sender: gaps of random length between bursts
    task automatic maybe_gap();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 6);
            if ($urandom_range(0, 1)) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_sample(int row, int col, int smp);
        send_beat(CMD_WRITE, row[5:0], col[5:0], smp[SAMPLE_W-1:0],
                  COORD_W'($urandom()), COORD_W'($urandom()));
    endtask

    task automatic query_point(int qx, int qy);
        send_beat(CMD_QUERY, 6'($urandom()), 6'($urandom()), SAMPLE_W'($urandom()),
                  qx[COORD_W-1:0], qy[COORD_W-1:0]);
    endtask

    // wait until the block drained, then idle for the SETTLE period
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // one write beat, then idle with the enable low
    task automatic write_reg(logic [CFG_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int eff(int r);
        if (r == 0) return 1;
        if (r > DEF_MAX_ROWS) return DEF_MAX_ROWS;
        return r;
    endfunction

    // one coordinate: mostly inside the used span (size above one), some edge and wild values
    function automatic int pick_coord(int size);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7 && size > 1) return $urandom_range(0, (size - 1) * ONE - 1);
        if (sel == 7) return (size - 1) * ONE + $urandom_range(0, 2 * ONE);
        if (sel == 8) return -$urandom_range(1, 3 * ONE);
        return $signed($urandom_range(0, (1 << COORD_W) - 1) - (1 << (COORD_W - 1)));
    endfunction

    initial begin
        int rows_tab [PHASES];
        int cols_tab [PHASES];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load every entry that a size setting below can reach: the first
        // LOAD_COLS columns of every row and all of row zero. Extremes sit in
        // the top-left corner for the directed queries.
        for (int r = 0; r < DEF_MAX_ROWS; r++)
            for (int c = 0; c < DEF_MAX_COLS; c++) begin
                if (c < LOAD_COLS || r == 0) begin
                    if (r < 2 && c < 2)
                        write_sample(r, c, ((r + c) % 2) ? -32768 : 32767);
                    else
                        write_sample(r, c, $urandom_range(0, 65535) - 32768);
                    maybe_gap();
                end
            end

        // directed queries at reset size 4x4
        query_point(0, 0);
        query_point(ONE / 2, ONE / 2);
        query_point(3 * ONE - 1, 3 * ONE - 1);          // last point inside
        query_point(3 * ONE, ONE);                      // on the upper edge: clamped
        query_point(-1, ONE);                           // just below zero
        query_point(131071, 131071);
        query_point(-131072, -131072);
        query_point(-131072, 131071);
        query_point(ONE + 1, 2 * ONE + ONE / 2);
        query_point(2 * ONE + 1023, 5);
        write_sample(63, 63, -32768);                   // write to the last storage cell
        write_sample(0, 63, 32767);
        drain();

        // phases: single cell, tall grid, zero and oversized registers, narrow grids
        rows_tab = '{1, 64, 0, 2, 127, 64, 0, 0};
        cols_tab = '{1, 8, 127, 3, 0, 2, 0, 0};
        rows_tab[6] = $urandom_range(1, 64); cols_tab[6] = $urandom_range(1, LOAD_COLS);
        rows_tab[7] = $urandom_range(1, 8);  cols_tab[7] = $urandom_range(1, LOAD_COLS);
        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(REG_GRID_ROWS, rows_tab[ph][CFG_W-1:0]);
            write_reg(REG_GRID_COLS, cols_tab[ph][CFG_W-1:0]);
            write_reg(7'd2 + ph[CFG_W-1:0], CFG_W'($urandom()));   // unused index
            cur_rows = eff(rows_tab[ph]);
            cur_cols = eff(cols_tab[ph]);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ($urandom_range(0, 4) == 0)
                    write_sample($urandom_range(0, 63), $urandom_range(0, 63),
                                 $urandom_range(0, 65535) - 32768);
                else
                    query_point(pick_coord(cur_cols), pick_coord(cur_rows));
                maybe_gap();
            end
            drain();
        end

        $display("Run covered %0d grid writes and %0d queries over %0d size settings,",
                 write_beats, query_beats, PHASES + 1);
        $display("with %0d results checked, clamped and inside points included.", results);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
